@@ design/etmm_pkg.sv @@
`timescale 1ns / 1ps
package etmm_pkg;

  // Q2.14 one and polynomial coefficients of the quarter-wave sine
  localparam int unsigned Q14_ONE = 16384;
  localparam logic [16:0] SIN_C1  = 17'd84093;
  localparam logic [13:0] SIN_C2  = 14'd9279;
  localparam logic [17:0] SIN_C3  = 18'd205887;

  // column index of the translation column
  localparam logic [1:0] COL_TRANS = 2'd3;

  typedef logic signed [15:0] q14_t;
  typedef logic signed [31:0] q16_t;

  // Q42 sum to Q2.14: round half away from zero, clamp to +-one
  function automatic q14_t rot_round(input logic signed [44:0] v);
    logic [44:0] mag;
    logic [44:0] r;
    logic [15:0] m;
    mag = v[44] ? 45'(-v) : 45'(v);
    r   = (mag + 45'd134217728) >> 28;
    m   = (r > 45'(Q14_ONE)) ? 16'(Q14_ONE) : r[15:0];
    return v[44] ? q14_t'(-m) : q14_t'(m);
  endfunction

  // Q2.14 x Q16.16 product to Q16.16: round half away from zero, saturate
  function automatic q16_t mat_round(input logic signed [47:0] v);
    logic [47:0] mag;
    logic [47:0] r;
    q16_t        res;
    mag = v[47] ? 48'(-v) : 48'(v);
    r   = (mag + 48'd8192) >> 14;
    if (v[47]) begin
      if (r >= 48'h8000_0000) res = 32'sh8000_0000;
      else res = q16_t'(-r[31:0]);
    end else begin
      if (r > 48'h7fff_ffff) res = 32'sh7fff_ffff;
      else res = q16_t'(r[31:0]);
    end
    return res;
  endfunction

endpackage

@@ design/euler_trs_model_matrix.sv @@
`timescale 1ns / 1ps
// Each item passes the arithmetic pipeline and the column hold registers; its columns then follow in order.
// A new start is refused while busy_o is high, set by the four columns sharing one result port.
// The eight-stage arithmetic pipeline itself takes an item in every cycle.
// Reset (rst_ni, async, active low) clears busy, stage valid bits and the column sequencer.
// The receiver cannot stall: every column is shown for exactly one cycle under valid_o.
module euler_trs_model_matrix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic        [15:0] angle_x_i,
  input  logic        [15:0] angle_y_i,
  input  logic        [15:0] angle_z_i,
  input  logic signed [31:0] scale_x_i,
  input  logic signed [31:0] scale_y_i,
  input  logic signed [31:0] scale_z_i,
  output logic               valid_o,
  output logic        [1:0]  column_o,
  output logic signed [31:0] m_x_o,
  output logic signed [31:0] m_y_o,
  output logic signed [31:0] m_z_o,
  output logic signed [15:0] basis_x_o,
  output logic signed [15:0] basis_y_o,
  output logic signed [15:0] basis_z_o,
  output logic               last_o
);

  // sine unit order: sin x, cos x, sin y, cos y, sin z, cos z
  localparam int NS = 6;
  localparam int NV = 8;

  logic        accept;
  logic [1:0]  busy_cnt_q, busy_cnt_d;
  logic [NV-1:0] vld_q;

  logic [15:0] ang [NS];

  // stage registers of the sine units
  logic [14:0] x1_q [NS], x2_q [NS], x3_q [NS];
  logic [14:0] t1_q [NS], t2_q [NS];
  logic [16:0] in2_q [NS];
  logic [17:0] mid3_q [NS];
  logic        ng1_q [NS], ng2_q [NS], ng3_q [NS];
  etmm_pkg::q14_t s4_q [NS];

  // position and scale ride along the pipeline
  etmm_pkg::q16_t pos_q [NV][3];
  etmm_pkg::q16_t scl_q [NV][3];

  // rotation stages
  logic signed [31:0] p5_q [10];
  etmm_pkg::q14_t     sy5_q, sx5_q, cx5_q;
  logic signed [44:0] a6_q [9], b6_q [9];
  etmm_pkg::q14_t     r7_q [9];
  etmm_pkg::q14_t     r8_q [9];
  logic signed [47:0] mp8_q [9];

  // column hold registers and sequencer
  etmm_pkg::q16_t m_q  [4][3];
  etmm_pkg::q14_t bs_q [3][3];
  logic [1:0]     col_q;
  logic           act_q;

  assign accept = start_i && !busy_o;
  assign busy_o = (busy_cnt_q != 2'd0);

  // input pacing: after each accepted transfer, busy_o refuses further transfers
  always_comb begin
    busy_cnt_d = busy_cnt_q;
    if (accept) busy_cnt_d = 2'd3;
    else if (busy_cnt_q != 2'd0) busy_cnt_d = busy_cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_cnt_q <= 2'd0;
      vld_q      <= '0;
    end else begin
      busy_cnt_q <= busy_cnt_d;
      vld_q      <= {vld_q[NV-2:0], accept};
    end
  end

  assign ang[0] = angle_x_i;
  assign ang[1] = angle_x_i + 16'h4000;
  assign ang[2] = angle_y_i;
  assign ang[3] = angle_y_i + 16'h4000;
  assign ang[4] = angle_z_i;
  assign ang[5] = angle_z_i + 16'h4000;

  // sine pipeline: x and x^2, inner term, mid term, final product
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NS; i++) begin
      logic [14:0] xs;
      logic [29:0] sq;
      logic [28:0] pa;
      logic [31:0] pb;
      logic [32:0] pc;
      logic [15:0] rr;
      xs = ang[i][14] ? 15'(15'(etmm_pkg::Q14_ONE) - 15'(ang[i][13:0]))
                      : 15'(ang[i][13:0]);
      sq = 30'(xs) * 30'(xs);
      x1_q[i]  <= xs;
      t1_q[i]  <= sq[28:14];
      ng1_q[i] <= ang[i][15];

      pa = 29'(etmm_pkg::SIN_C2) * 29'(t1_q[i]);
      x2_q[i]  <= x1_q[i];
      t2_q[i]  <= t1_q[i];
      ng2_q[i] <= ng1_q[i];
      in2_q[i] <= etmm_pkg::SIN_C1 - 17'(pa[28:14]);

      pb = 32'(t2_q[i]) * 32'(in2_q[i]);
      x3_q[i]   <= x2_q[i];
      ng3_q[i]  <= ng2_q[i];
      mid3_q[i] <= etmm_pkg::SIN_C3 - pb[31:14];

      pc = 33'(x3_q[i]) * 33'(mid3_q[i]);
      rr = (pc[32:17] > 16'(etmm_pkg::Q14_ONE)) ? 16'(etmm_pkg::Q14_ONE) : pc[32:17];
      s4_q[i] <= ng3_q[i] ? etmm_pkg::q14_t'(-rr) : etmm_pkg::q14_t'(rr);
    end
  end

  // side payload
  always_ff @(posedge clk_i) begin
    pos_q[0][0] <= pos_x_i;
    pos_q[0][1] <= pos_y_i;
    pos_q[0][2] <= pos_z_i;
    scl_q[0][0] <= scale_x_i;
    scl_q[0][1] <= scale_y_i;
    scl_q[0][2] <= scale_z_i;
    for (int s = 1; s < NV; s++) begin
      for (int j = 0; j < 3; j++) begin
        pos_q[s][j] <= pos_q[s-1][j];
        scl_q[s][j] <= scl_q[s-1][j];
      end
    end
  end

  // rotation: pairwise products, triple products, rounded sums
  always_ff @(posedge clk_i) begin
    p5_q[0] <= s4_q[5] * s4_q[3];  // cz cy
    p5_q[1] <= s4_q[4] * s4_q[3];  // sz cy
    p5_q[2] <= s4_q[5] * s4_q[2];  // cz sy
    p5_q[3] <= s4_q[4] * s4_q[2];  // sz sy
    p5_q[4] <= s4_q[3] * s4_q[0];  // cy sx
    p5_q[5] <= s4_q[3] * s4_q[1];  // cy cx
    p5_q[6] <= s4_q[4] * s4_q[1];  // sz cx
    p5_q[7] <= s4_q[5] * s4_q[1];  // cz cx
    p5_q[8] <= s4_q[4] * s4_q[0];  // sz sx
    p5_q[9] <= s4_q[5] * s4_q[0];  // cz sx
    sy5_q <= s4_q[2];
    sx5_q <= s4_q[0];
    cx5_q <= s4_q[1];

    // index = column * 3 + row
    a6_q[0] <= 45'(p5_q[0]) <<< 14;
    b6_q[0] <= '0;
    a6_q[1] <= 45'(p5_q[1]) <<< 14;
    b6_q[1] <= '0;
    a6_q[2] <= -(45'(sy5_q) <<< 28);
    b6_q[2] <= '0;
    a6_q[3] <= 45'(p5_q[2]) * 45'(sx5_q);
    b6_q[3] <= -(45'(p5_q[6]) <<< 14);
    a6_q[4] <= 45'(p5_q[3]) * 45'(sx5_q);
    b6_q[4] <= 45'(p5_q[7]) <<< 14;
    a6_q[5] <= 45'(p5_q[4]) <<< 14;
    b6_q[5] <= '0;
    a6_q[6] <= 45'(p5_q[2]) * 45'(cx5_q);
    b6_q[6] <= 45'(p5_q[8]) <<< 14;
    a6_q[7] <= 45'(p5_q[3]) * 45'(cx5_q);
    b6_q[7] <= -(45'(p5_q[9]) <<< 14);
    a6_q[8] <= 45'(p5_q[5]) <<< 14;
    b6_q[8] <= '0;

    // rounded entries travel on beside their scaled products
    for (int e = 0; e < 9; e++) begin
      r7_q[e]  <= etmm_pkg::rot_round(a6_q[e] + b6_q[e]);
      r8_q[e]  <= r7_q[e];
      mp8_q[e] <= 48'(r7_q[e]) * 48'(scl_q[6][e/3]);
    end
  end

  // column hold registers, loaded as an item leaves the pipeline
  always_ff @(posedge clk_i) begin
    if (vld_q[NV-1]) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          m_q[k][i]  <= etmm_pkg::mat_round(mp8_q[k*3+i]);
          bs_q[k][i] <= (k == 2) ? etmm_pkg::q14_t'(-r8_q[k*3+i]) : r8_q[k*3+i];
        end
      end
      for (int i = 0; i < 3; i++) m_q[3][i] <= pos_q[NV-1][i];
    end
  end

  // column sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      col_q <= 2'd0;
    end else if (vld_q[NV-1]) begin
      act_q <= 1'b1;
      col_q <= 2'd0;
    end else if (act_q) begin
      col_q <= col_q + 2'd1;
      if (col_q == etmm_pkg::COL_TRANS) act_q <= 1'b0;
    end
  end

  // result port
  assign valid_o  = act_q;
  assign column_o = col_q;
  assign last_o   = act_q && (col_q == etmm_pkg::COL_TRANS);
  assign m_x_o    = m_q[col_q][0];
  assign m_y_o    = m_q[col_q][1];
  assign m_z_o    = m_q[col_q][2];
  assign basis_x_o = (col_q == etmm_pkg::COL_TRANS) ? '0 : bs_q[col_q[1] ? 2'd2 : col_q][0];
  assign basis_y_o = (col_q == etmm_pkg::COL_TRANS) ? '0 : bs_q[col_q[1] ? 2'd2 : col_q][1];
  assign basis_z_o = (col_q == etmm_pkg::COL_TRANS) ? '0 : bs_q[col_q[1] ? 2'd2 : col_q][2];

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
module tb;

  localparam int Q1 = 16384;

  typedef struct packed {
    logic [1:0]  column;
    logic [31:0] m_x, m_y, m_z;
    logic [15:0] b_x, b_y, b_z;
    logic        last;
  } column_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [15:0] angle_x_i = '0, angle_y_i = '0, angle_z_i = '0;
  logic signed [31:0] scale_x_i = '0, scale_y_i = '0, scale_z_i = '0;
  logic valid_o, last_o;
  logic [1:0] column_o;
  logic signed [31:0] m_x_o, m_y_o, m_z_o;
  logic signed [15:0] basis_x_o, basis_y_o, basis_z_o;

  column_t expected_cols[$];
  int      errors = 0;

  euler_trs_model_matrix dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // quarter-wave polynomial sine, Q2.14
  function automatic longint quarter_sin(longint x);
    longint t2, inner, mid, r;
    t2 = (x * x) >>> 14;
    inner = 84093 - ((9279 * t2) >>> 14);
    mid = 205887 - ((t2 * inner) >>> 14);
    r = (x * mid) >>> 17;
    return (r > Q1) ? Q1 : r;
  endfunction

  function automatic longint bin_sin(logic [15:0] a);
    longint f, s;
    f = a[13:0];
    s = quarter_sin(a[14] ? Q1 - f : f);
    return a[15] ? -s : s;
  endfunction

  function automatic longint rnd_shift(longint v, int sh);
    longint half;
    half = longint'(1) <<< (sh - 1);
    return (v >= 0) ? ((v + half) >>> sh) : -((-v + half) >>> sh);
  endfunction

  function automatic longint rot_q14(longint q42);
    longint v;
    v = rnd_shift(q42, 28);
    return (v > Q1) ? Q1 : ((v < -Q1) ? -Q1 : v);
  endfunction

  function automatic logic [31:0] scaled_entry(longint r, longint s);
    longint v;
    v = rnd_shift(r * s, 14);
    if (v > 64'sh7fffffff) v = 64'sh7fffffff;
    if (v < -64'sh80000000) v = -64'sh80000000;
    return v[31:0];
  endfunction

  // append one expected column to the scoreboard
  task automatic queue_column(column_t c);
    expected_cols = {expected_cols, c};
  endtask

  // expected four columns of T*R*S
  task automatic predict_matrix();
    longint sx, cx, sy, cy, sz, cz;
    longint r[3][3];
    longint scl[3];
    column_t c;
    sx = bin_sin(angle_x_i); cx = bin_sin(angle_x_i + 16'd16384);
    sy = bin_sin(angle_y_i); cy = bin_sin(angle_y_i + 16'd16384);
    sz = bin_sin(angle_z_i); cz = bin_sin(angle_z_i + 16'd16384);
    r[0][0] = rot_q14(cz * cy * Q1);
    r[1][0] = rot_q14(sz * cy * Q1);
    r[2][0] = rot_q14(-sy * Q1 * Q1);
    r[0][1] = rot_q14(cz * sy * sx - sz * cx * Q1);
    r[1][1] = rot_q14(sz * sy * sx + cz * cx * Q1);
    r[2][1] = rot_q14(cy * sx * Q1);
    r[0][2] = rot_q14(cz * sy * cx + sz * sx * Q1);
    r[1][2] = rot_q14(sz * sy * cx - cz * sx * Q1);
    r[2][2] = rot_q14(cy * cx * Q1);
    scl[0] = scale_x_i; scl[1] = scale_y_i; scl[2] = scale_z_i;
    for (int k = 0; k < 3; k++) begin
      c.column = k[1:0];
      c.m_x = scaled_entry(r[0][k], scl[k]);
      c.m_y = scaled_entry(r[1][k], scl[k]);
      c.m_z = scaled_entry(r[2][k], scl[k]);
      c.b_x = 16'((k == 2) ? -r[0][k] : r[0][k]);
      c.b_y = 16'((k == 2) ? -r[1][k] : r[1][k]);
      c.b_z = 16'((k == 2) ? -r[2][k] : r[2][k]);
      c.last = 1'b0;
      queue_column(c);
    end
    c = '{etmm_pkg::COL_TRANS, pos_x_i, pos_y_i, pos_z_i, 16'd0, 16'd0, 16'd0, 1'b1};
    queue_column(c);
  endtask

  // one start transfer; start stays high into the next call when there is no gap
  task automatic send_pose(logic [31:0] px, py, pz, logic [15:0] ax, ay, az,
                           logic [31:0] kx, ky, kz);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pos_x_i <= px; pos_y_i <= py; pos_z_i <= pz;
    angle_x_i <= ax; angle_y_i <= ay; angle_z_i <= az;
    scale_x_i <= kx; scale_y_i <= ky; scale_z_i <= kz;
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_matrix();
    @(negedge clk_i);
  endtask

  // check each column strobe against the oldest expectation
  always @(posedge clk_i) begin
    column_t got, want;
    if (rst_ni && valid_o) begin
      got = '{column_o, m_x_o, m_y_o, m_z_o, basis_x_o, basis_y_o, basis_z_o, last_o};
      if (expected_cols.size() == 0) begin
        $display("%0t: unexpected column %h", $time, got);
        errors++;
      end else begin
        want = expected_cols.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 7)) << 13;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic test_extremes();
    logic [15:0] quads[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000,
                              16'hffff, 16'h3fff, 16'h2000, 16'h0001};
    send_pose(32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0,
              32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_pose(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 16'd0, 16'd0, 16'd0,
              32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    foreach (quads[i])
      send_pose(i, -i, 32'h1234_5678, quads[i], quads[(i + 3) % 8], quads[(i + 5) % 8],
                32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
    send_pose(32'hffff_ffff, 32'd0, 32'h5555_5555, 16'hffff, 16'hffff, 16'hffff,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_pose(32'd0, 32'haaaa_aaaa, 32'd0, 16'h8000, 16'h4000, 16'hc000,
              32'd0, 32'd0, 32'd0);
  endtask

  task automatic test_random();
    for (int n = 0; n < 320; n++)
      send_pose(rand_word(), rand_word(), rand_word(), rand_angle(), rand_angle(),
                rand_angle(), rand_word(), rand_word(), rand_word());
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_extremes();
    test_random();
    start_i <= 1'b0;
    while (expected_cols.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
